// ===== hdl/cef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_pkg: shared types and constants of the cosine eased color fade
// Field widths, register codes, controller commands and the ease table.
// ----------------------------------------------------------------------------
package cef_pkg;

	localparam int unsigned DELTA_W   = 16;
	localparam int unsigned COLOR_W   = 24;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned OPA_W     = 9;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned EASE_W    = 16;
	localparam int unsigned MIX_W     = 16;
	localparam int unsigned ACC_W     = 32;

	localparam int unsigned EASE_TABLE_BITS_DEF = 10;

	localparam logic [OPA_W-1:0]  OPA_ONE  = 9'd256;
	localparam logic [EASE_W-1:0] EASE_ONE = 16'h8000;

	// register reset values
	localparam logic [COLOR_W-1:0] BASE_COLOR_RST       = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RST = 24'h000000;
	localparam logic [OPA_W-1:0]   OPACITY_START_RST    = 9'd0;
	localparam logic [OPA_W-1:0]   OPACITY_END_RST      = 9'd256;
	localparam logic [TIME_W-1:0]  FADE_LENGTH_RST      = 32'd1000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_COLOR       = 3'd0,
		REG_BACKGROUND_COLOR = 3'd1,
		REG_OPACITY_START    = 3'd2,
		REG_OPACITY_END      = 3'd3,
		REG_FADE_LENGTH      = 3'd4
	} cef_reg_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} cef_chan_t;

	// multiplier operand selects
	typedef enum logic [1:0] {
		A_BASE,
		A_BG,
		A_CS,
		A_CE
	} cef_asel_t;

	typedef enum logic [1:0] {
		B_OP,
		B_OPINV,
		B_EINV,
		B_E
	} cef_bsel_t;

	typedef struct packed {
		logic      cap_delta;
		logic      clr_time;
		logic      add_time;
		logic      div_load;
		logic      div_step;
		logic      tab_rd;
		cef_asel_t a_sel;
		cef_bsel_t b_sel;
		logic      op_end;
		logic      acc_en;
		logic      acc_load;
		logic      save_cs;
		logic      save_ce;
		logic      wr_mix;
		logic      wr_blend;
		cef_chan_t chan;
		logic      load_out;
		logic      ongoing;
	} cef_cmd_t;

	typedef struct packed {
		logic fin;
	} cef_sts_t;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// ease table entry: round(32768 * sin^2(pi*idx / 2^(bits+1))), Q30 Taylor series
	function automatic logic [EASE_W-1:0] ease_entry(input int unsigned idx,
		input int unsigned bits);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		x = (PI_Q30 * 64'(idx)) >> (bits + 1);
		term = x;
		sum = x;
		for (int j = 0; j < 7; j++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / TAYLOR_DIV[j];
			if (!j[0]) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > (64'd1 << 30)) begin
			sum = 64'd1 << 30;
		end
		e = (sum * sum + (64'd1 << 44)) >> 45;
		if (e > 64'(EASE_ONE)) begin
			e = 64'(EASE_ONE);
		end
		return e[EASE_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cef_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_ifs: channel interfaces of the cosine eased color fade
// Tick input, color result and register write channels.
// ----------------------------------------------------------------------------
interface cef_tick_if;
	import cef_pkg::*;
	logic               valid;
	logic               ready;
	logic [DELTA_W-1:0] frame_delta;
	modport source(output valid, output frame_delta, input ready);
	modport sink(input valid, input frame_delta, output ready);
endinterface

interface cef_color_if;
	import cef_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] center_red;
	logic [CHAN_W-1:0] center_green;
	logic [CHAN_W-1:0] center_blue;
	logic              ongoing;
	modport source(output valid, output center_red, output center_green,
		output center_blue, output ongoing, input ready);
	modport sink(input valid, input center_red, input center_green,
		input center_blue, input ongoing, output ready);
endinterface

interface cef_cfg_if;
	import cef_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/cef_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_datapath: registers, divider, ease table and shared multiplier
// Executes one controller command per cycle and reports the finish test.
// ----------------------------------------------------------------------------
module cef_datapath #(
	parameter int unsigned EASE_TABLE_BITS = cef_pkg::EASE_TABLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cef_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic [cef_pkg::DELTA_W-1:0]   tick_delta,
	input  wire cef_pkg::cef_cmd_t             cmd,
	output cef_pkg::cef_sts_t                  sts,
	output logic [cef_pkg::CHAN_W-1:0]         center_red,
	output logic [cef_pkg::CHAN_W-1:0]         center_green,
	output logic [cef_pkg::CHAN_W-1:0]         center_blue,
	output logic                               ongoing
);
	import cef_pkg::*;

	localparam int unsigned QUO_W     = EASE_TABLE_BITS + 1;
	localparam int unsigned NUM_W     = TIME_W + QUO_W;
	localparam int unsigned TAB_DEPTH = (1 << EASE_TABLE_BITS) + 1;
	localparam logic [QUO_W-1:0] IDX_MAX = QUO_W'(1) << EASE_TABLE_BITS;

	// configuration registers
	logic [COLOR_W-1:0] base_q;
	logic [COLOR_W-1:0] bg_q;
	logic [OPA_W-1:0]   ops_q;
	logic [OPA_W-1:0]   ope_q;
	logic [TIME_W-1:0]  len_q;

	logic [TIME_W-1:0]  elapsed_q;
	logic [DELTA_W-1:0] delta_q;
	logic [TIME_W-1:0]  rem_q;
	logic [QUO_W-1:0]   lo_q;
	logic [QUO_W-1:0]   quo_q;
	logic [EASE_W-1:0]  ease_q;
	logic [ACC_W-1:0]   acc_q;
	logic [MIX_W-1:0]   cs_q;
	logic [MIX_W-1:0]   ce_q;
	logic [CHAN_W-1:0]  col_q [3];
	logic [CHAN_W-1:0]  red_q;
	logic [CHAN_W-1:0]  green_q;
	logic [CHAN_W-1:0]  blue_q;
	logic               ongoing_q;

	logic [EASE_W-1:0]  ease_tab [TAB_DEPTH];
	logic [TIME_W:0]    time_sum;
	logic [NUM_W-1:0]   num;
	logic [TIME_W:0]    trial;
	logic [TIME_W:0]    diff;
	logic               ge;
	logic [QUO_W-1:0]   idx;
	logic [CHAN_W-1:0]  base_ch;
	logic [CHAN_W-1:0]  bg_ch;
	logic [OPA_W-1:0]   op_sel;
	logic [OPA_W-1:0]   op_sat;
	logic [MIX_W-1:0]   mul_a;
	logic [EASE_W-1:0]  mul_b;
	logic [ACC_W-1:0]   prod;
	logic [MIX_W:0]     mix_rnd;
	logic [ACC_W-1:0]   blend_rnd;

	// constant ease table, built at elaboration
	for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
		assign ease_tab[g] = ease_entry(g, EASE_TABLE_BITS);
	end

	// saturating time add and finish test
	assign time_sum = {1'b0, elapsed_q} + (TIME_W + 1)'(delta_q);
	assign sts.fin  = (len_q == '0) || (elapsed_q > len_q);

	// restoring divider, one quotient bit per step
	assign num   = {elapsed_q, {EASE_TABLE_BITS{1'b0}}, 1'b0} >> 1;
	assign trial = {rem_q, lo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, len_q};
	assign ge    = trial >= {1'b0, len_q};
	assign idx   = (quo_q > IDX_MAX) ? IDX_MAX : quo_q;

	// channel and opacity selection
	always_comb begin
		case (cmd.chan)
			CH_RED: begin
				base_ch = base_q[23:16];
				bg_ch   = bg_q[23:16];
			end
			CH_GREEN: begin
				base_ch = base_q[15:8];
				bg_ch   = bg_q[15:8];
			end
			default: begin
				base_ch = base_q[7:0];
				bg_ch   = bg_q[7:0];
			end
		endcase
		op_sel = cmd.op_end ? ope_q : ops_q;
		op_sat = (op_sel > OPA_ONE) ? OPA_ONE : op_sel;
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.a_sel)
			A_BASE:  mul_a = MIX_W'(base_ch);
			A_BG:    mul_a = MIX_W'(bg_ch);
			A_CS:    mul_a = cs_q;
			default: mul_a = ce_q;
		endcase
		case (cmd.b_sel)
			B_OP:    mul_b = EASE_W'(op_sat);
			B_OPINV: mul_b = EASE_W'(OPA_ONE - op_sat);
			B_EINV:  mul_b = EASE_ONE - ease_q;
			default: mul_b = ease_q;
		endcase
	end

	assign prod      = ACC_W'(mul_a) * ACC_W'(mul_b);
	assign mix_rnd   = acc_q[MIX_W:0] + (MIX_W + 1)'(128);
	assign blend_rnd = acc_q + (ACC_W'(1) << 22);

	// configuration writes and elapsed time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_COLOR_RST;
			bg_q      <= BACKGROUND_COLOR_RST;
			ops_q     <= OPACITY_START_RST;
			ope_q     <= OPACITY_END_RST;
			len_q     <= FADE_LENGTH_RST;
			elapsed_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_COLOR:       base_q <= cfg_data[COLOR_W-1:0];
					REG_BACKGROUND_COLOR: bg_q   <= cfg_data[COLOR_W-1:0];
					REG_OPACITY_START:    ops_q  <= cfg_data[OPA_W-1:0];
					REG_OPACITY_END:      ope_q  <= cfg_data[OPA_W-1:0];
					REG_FADE_LENGTH:      len_q  <= cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_time) begin
				elapsed_q <= '0;
			end else if (cmd.add_time) begin
				elapsed_q <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.cap_delta) begin
			delta_q <= tick_delta;
		end
		if (cmd.div_load) begin
			rem_q <= TIME_W'(NUM_W'(num + NUM_W'(len_q[TIME_W-1:1])) >> QUO_W);
			lo_q  <= QUO_W'(num + NUM_W'(len_q[TIME_W-1:1]));
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (cmd.tab_rd) begin
			ease_q <= ease_tab[idx];
		end
		if (cmd.acc_en) begin
			acc_q <= cmd.acc_load ? prod : acc_q + prod;
		end
		if (cmd.save_cs) begin
			cs_q <= acc_q[MIX_W-1:0];
		end
		if (cmd.save_ce) begin
			ce_q <= acc_q[MIX_W-1:0];
		end
		if (cmd.wr_mix) begin
			col_q[cmd.chan] <= mix_rnd[MIX_W-1:CHAN_W];
		end else if (cmd.wr_blend) begin
			col_q[cmd.chan] <= blend_rnd[30:23];
		end
		if (cmd.load_out) begin
			red_q     <= col_q[CH_RED];
			green_q   <= col_q[CH_GREEN];
			blue_q    <= col_q[CH_BLUE];
			ongoing_q <= cmd.ongoing;
		end
	end

	assign center_red   = red_q;
	assign center_green = green_q;
	assign center_blue  = blue_q;
	assign ongoing      = ongoing_q;

endmodule
`default_nettype wire

// ===== hdl/cef_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_ctrl: fade controller
// Tracks the fade stage, sequences the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module cef_ctrl #(
	parameter int unsigned EASE_TABLE_BITS = cef_pkg::EASE_TABLE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire cef_pkg::cef_sts_t sts,
	output cef_pkg::cef_cmd_t      cmd
);
	import cef_pkg::*;

	localparam int unsigned CNT_W = $clog2(EASE_TABLE_BITS + 1);
	localparam logic [2:0] STEP_MIX_LAST   = 3'd2;
	localparam logic [2:0] STEP_BLEND_LAST = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_CHK,
		S_DIV,
		S_TAB,
		S_MIX,
		S_BLEND,
		S_PUT
	} state_t;

	typedef enum logic [1:0] {
		FS_NEW    = 2'd0,
		FS_FADING = 2'd1,
		FS_DONE   = 2'd2
	} stage_t;

	state_t           state_q;
	stage_t           stage_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       step_q;
	cef_chan_t        chan_q;
	logic             use_end_q;
	logic             ongoing_q;
	logic             out_valid_q;
	logic             accept;
	logic             put;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign put       = !out_valid_q || out_ready;

	function automatic cef_chan_t chan_next(input cef_chan_t c);
		case (c)
			CH_RED:   return CH_GREEN;
			CH_GREEN: return CH_BLUE;
			default:  return CH_RED;
		endcase
	endfunction

	// state, stage and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stage_q     <= FS_NEW;
			cnt_q       <= '0;
			step_q      <= '0;
			chan_q      <= CH_RED;
			use_end_q   <= 1'b0;
			ongoing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop valid once taken; S_PUT handles valid itself
			if (out_ready && state_q != S_PUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					chan_q <= CH_RED;
					if (accept) begin
						case (stage_q)
							FS_NEW: begin
								stage_q   <= FS_FADING;
								use_end_q <= 1'b0;
								ongoing_q <= 1'b1;
								state_q   <= S_MIX;
							end
							FS_FADING: begin
								state_q <= S_ADD;
							end
							default: begin
								use_end_q <= 1'b1;
								ongoing_q <= 1'b0;
								state_q   <= S_MIX;
							end
						endcase
					end
				end
				S_ADD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					cnt_q <= '0;
					if (sts.fin) begin
						stage_q   <= FS_DONE;
						use_end_q <= 1'b1;
						ongoing_q <= 1'b0;
						state_q   <= S_MIX;
					end else begin
						ongoing_q <= 1'b1;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(EASE_TABLE_BITS)) begin
						state_q <= S_TAB;
					end
				end
				S_TAB: begin
					state_q <= S_BLEND;
				end
				S_MIX, S_BLEND: begin
					if ((state_q == S_MIX && step_q == STEP_MIX_LAST) ||
						(state_q == S_BLEND && step_q == STEP_BLEND_LAST)) begin
						step_q <= '0;
						chan_q <= chan_next(chan_q);
						if (chan_q == CH_BLUE) begin
							state_q <= S_PUT;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_PUT: begin
					if (put) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.a_sel    = A_BASE;
		cmd.b_sel    = B_OP;
		cmd.chan     = chan_q;
		cmd.op_end   = use_end_q;
		cmd.ongoing  = ongoing_q;
		case (state_q)
			S_IDLE: begin
				cmd.cap_delta = accept;
				cmd.clr_time  = accept && (stage_q == FS_NEW);
			end
			S_ADD: begin
				cmd.add_time = 1'b1;
			end
			S_CHK: begin
				cmd.div_load = !sts.fin;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_TAB: begin
				cmd.tab_rd = 1'b1;
			end
			S_MIX: begin
				case (step_q)
					3'd0: begin
						cmd.acc_en   = 1'b1;
						cmd.acc_load = 1'b1;
					end
					3'd1: begin
						cmd.acc_en = 1'b1;
						cmd.a_sel  = A_BG;
						cmd.b_sel  = B_OPINV;
					end
					default: begin
						cmd.wr_mix = 1'b1;
					end
				endcase
			end
			S_BLEND: begin
				case (step_q)
					3'd0: begin
						cmd.acc_en   = 1'b1;
						cmd.acc_load = 1'b1;
						cmd.op_end   = 1'b0;
					end
					3'd1: begin
						cmd.acc_en = 1'b1;
						cmd.a_sel  = A_BG;
						cmd.b_sel  = B_OPINV;
						cmd.op_end = 1'b0;
					end
					3'd2: begin
						cmd.save_cs  = 1'b1;
						cmd.acc_en   = 1'b1;
						cmd.acc_load = 1'b1;
						cmd.op_end   = 1'b1;
					end
					3'd3: begin
						cmd.acc_en = 1'b1;
						cmd.a_sel  = A_BG;
						cmd.b_sel  = B_OPINV;
						cmd.op_end = 1'b1;
					end
					3'd4: begin
						cmd.save_ce  = 1'b1;
						cmd.acc_en   = 1'b1;
						cmd.acc_load = 1'b1;
						cmd.a_sel    = A_CS;
						cmd.b_sel    = B_EINV;
					end
					3'd5: begin
						cmd.acc_en = 1'b1;
						cmd.a_sel  = A_CE;
						cmd.b_sel  = B_E;
					end
					default: begin
						cmd.wr_blend = 1'b1;
					end
				endcase
			end
			S_PUT: begin
				cmd.load_out = put;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/cosine_eased_color_fade_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_eased_color_fade_top: one-shot cosine eased RGB crossfade
//
// Channels: tick carries frame_delta, one transaction per display frame.
// color returns one transaction per tick: center_red/green/blue and ongoing.
// cfg writes the registers base_color, background_color, opacity_start,
// opacity_end and fade_length at indexes 0 to 4; it is always ready.
// Work per tick: the first tick and every tick after the fade has ended run
// three channel mixes of three steps each on the shared multiplier; the tick
// that ends the fade runs the time add and the finish test before them. A
// fading tick runs the time add, the finish test, a restoring divider at one
// quotient bit per cycle, the ease table read and seven steps per channel,
// six of them on the shared multiplier. The color turns valid in the same
// cycle that the next tick can be taken.
// One tick is worked at a time; tick.ready is high only while the block is
// idle. A finished color waits in the output register while the next tick
// is taken; if the receiver stalls, work stops before that register.
// Reset: stage returns to not started, elapsed time to zero, and the
// registers to their reset values; no transaction is pending.
// ----------------------------------------------------------------------------
module cosine_eased_color_fade_top #(
	parameter int unsigned EASE_TABLE_BITS = cef_pkg::EASE_TABLE_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	cef_tick_if.sink    tick,
	cef_color_if.source color,
	cef_cfg_if.sink     cfg
);
	import cef_pkg::*;

	cef_cmd_t cmd;
	cef_sts_t sts;

	// register writes are taken in any cycle
	assign cfg.ready = 1'b1;

	cef_ctrl #(
		.EASE_TABLE_BITS(EASE_TABLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.out_valid(color.valid),
		.out_ready(color.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cef_datapath #(
		.EASE_TABLE_BITS(EASE_TABLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.tick_delta  (tick.frame_delta),
		.cmd         (cmd),
		.sts         (sts),
		.center_red  (color.center_red),
		.center_green(color.center_green),
		.center_blue (color.center_blue),
		.ongoing     (color.ongoing)
	);

endmodule
`default_nettype wire
